FILE: hdl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Types and character constants shared by the literal string escaper modules.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;

	localparam logic [2:0] LEN_PLAIN  = 3'd1;
	localparam logic [2:0] LEN_LETTER = 3'd2;
	localparam logic [2:0] LEN_OCTAL  = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_first;
		logic       is_last;
		logic       empty_string;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} enc_item_t;

	// classified work for the emitter: optional parens around up to four body chars
	typedef struct packed {
		logic            opn;
		logic            cls;
		logic [2:0]      body_len;
		logic [3:0][7:0] body;
	} desc_t;

endpackage

FILE: hdl/lse_front.sv
// ----------------------------------------------------------------------------
// lse_front
// Classifies one raw byte into an emit descriptor.
// ----------------------------------------------------------------------------
module lse_front
	import lse_pkg::*;
(
	input  raw_item_t item,
	output desc_t     desc
);

	logic [7:0] letter;
	logic       has_letter;

	always_comb begin
		has_letter = 1'b1;
		unique case (item.data_byte)
			8'h5C: letter = CH_BSLASH;
			8'h28: letter = CH_LPAREN;
			8'h29: letter = CH_RPAREN;
			8'h0A: letter = 8'h6E;
			8'h0D: letter = 8'h72;
			8'h09: letter = 8'h74;
			8'h08: letter = 8'h62;
			8'h0C: letter = 8'h66;
			default: begin
				letter     = 8'h00;
				has_letter = 1'b0;
			end
		endcase
	end

	always_comb begin
		desc.opn  = item.empty_string | item.is_first;
		desc.cls  = item.empty_string | item.is_last;
		desc.body = '0;
		if (item.empty_string) begin
			desc.body_len = 3'd0;
		end else if (has_letter) begin
			desc.body_len = LEN_LETTER;
			desc.body[0]  = CH_BSLASH;
			desc.body[1]  = letter;
		end else if (item.data_byte >= PRINT_LO && item.data_byte <= PRINT_HI) begin
			desc.body_len = LEN_PLAIN;
			desc.body[0]  = item.data_byte;
		end else begin
			desc.body_len = LEN_OCTAL;
			desc.body[0]  = CH_BSLASH;
			desc.body[1]  = CH_ZERO | {6'd0, item.data_byte[7:6]};
			desc.body[2]  = CH_ZERO | {5'd0, item.data_byte[5:3]};
			desc.body[3]  = CH_ZERO | {5'd0, item.data_byte[2:0]};
		end
	end

endmodule

FILE: hdl/lse_queue.sv
// ----------------------------------------------------------------------------
// lse_queue
// Small descriptor fifo between the classifier and the emitter.
// ----------------------------------------------------------------------------
module lse_queue
	import lse_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output desc_t rdata
);

	desc_t          mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   count_q;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> !pop) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");

endmodule

FILE: hdl/lse_back.sv
// ----------------------------------------------------------------------------
// lse_back
// Walks one descriptor a character per cycle into the output register, unless enc_stall holds it.
// ----------------------------------------------------------------------------
module lse_back
	import lse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  desc_t     head,
	output logic      pop,
	output logic      enc_valid,
	input  logic      enc_stall,
	output enc_item_t enc_data
);

	logic [2:0] pos_q;
	logic       out_valid_q;
	enc_item_t  out_q;

	logic [2:0] total;
	logic [2:0] idx;
	logic       is_last;
	logic       emit;
	enc_item_t  nxt;

	always_comb begin
		total   = {2'b00, head.opn} + head.body_len + {2'b00, head.cls};
		idx     = pos_q - {2'b00, head.opn};
		is_last = (pos_q == total - 3'd1);
		emit    = head_valid && (!out_valid_q || !enc_stall);
		pop     = emit && is_last;

		nxt.run_last   = is_last;
		nxt.string_end = 1'b0;
		if (head.opn && pos_q == 3'd0) begin
			nxt.out_byte = CH_LPAREN;
		end else if (idx < head.body_len) begin
			nxt.out_byte = head.body[idx[1:0]];
		end else begin
			// only the closing paren remains past the body
			nxt.out_byte   = CH_RPAREN;
			nxt.string_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				pos_q       <= is_last ? 3'd0 : pos_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!enc_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
	end

	assign enc_valid = out_valid_q;
	assign enc_data  = out_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < total) else $error("position past descriptor");
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (enc_valid && enc_data.run_last)) else $error("pop without last char");
	a_end_paren: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_valid && enc_data.string_end) |->
		(enc_data.out_byte == CH_RPAREN && enc_data.run_last))
		else $error("string end not on closing paren");
	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> pos_q == 3'd0) else $error("position held with no work");

endmodule

FILE: hdl/literal_string_escaper_top.sv
// ----------------------------------------------------------------------------
// literal_string_escaper_top
// PDF literal string encoder: raw bytes in, escaped characters out.
//
//   channel   handshake              payload
//   raw       raw_valid / raw_stall  raw_data (raw_item_t)
//   enc       enc_valid / enc_stall  enc_data (enc_item_t)
//
// each raw transaction yields one to six enc transactions, one per cycle while enc_stall is low
// the emitter is the limit: it sends the backslash and three octal digits of an escape one by one
// a four-entry descriptor queue lets raw transactions keep landing meanwhile
// raw_stall is high only while the queue is full
// reset empties the queue and the output register
// ----------------------------------------------------------------------------
module literal_string_escaper_top
	import lse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      raw_valid,
	output logic      raw_stall,
	input  raw_item_t raw_data,
	output logic      enc_valid,
	input  logic      enc_stall,
	output enc_item_t enc_data
);

	desc_t new_desc;
	desc_t head;
	logic  full;
	logic  nonempty;
	logic  pop;

	lse_front u_front (
		.item (raw_data),
		.desc (new_desc)
	);

	lse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (raw_valid && !full),
		.wdata    (new_desc),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rdata    (head)
	);

	lse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (nonempty),
		.head       (head),
		.pop        (pop),
		.enc_valid  (enc_valid),
		.enc_stall  (enc_stall),
		.enc_data   (enc_data)
	);

	assign raw_stall = full;

endmodule
